/* hdl/gbpw_pkg.sv */
package gbpw_pkg;

    localparam logic       KIND_START   = 1'b0;
    localparam logic       KIND_DATA    = 1'b1;

    localparam logic [7:0] GLYPH_MONO   = 8'd1;
    localparam logic [7:0] GLYPH_GRAY   = 8'd8;

    localparam logic [5:0] FB_DEPTH_8   = 6'd8;
    localparam logic [5:0] FB_DEPTH_16  = 6'd16;
    localparam logic [5:0] FB_DEPTH_32  = 6'd32;

    localparam logic [1:0] ST_WRITE     = 2'd0;
    localparam logic [1:0] ST_BAD_GLYPH = 2'd1;
    localparam logic [1:0] ST_BAD_FRAME = 2'd2;

    localparam logic [1:0] REG_FRAME_BASE   = 2'd0;
    localparam logic [1:0] REG_SCREEN_WIDTH = 2'd1;
    localparam logic [1:0] REG_FRAME_DEPTH  = 2'd2;

    localparam int         OUT_TDATA_BITS   = 72;

    typedef struct packed {
        logic [31:0] frame_base;
        logic [12:0] screen_width;
        logic [5:0]  frame_depth;
    } t_cfg;

    // one queued job: a group of pixels from one source byte, or a status report
    typedef struct packed {
        logic [1:0]  st;
        logic [7:0]  mask;
        logic [23:0] color;
    } t_job_hdr;

endpackage

/* hdl/gbpw_front.sv */
module gbpw_front #(
    parameter int COORD_BITS = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_queue_full,
    input  logic                  i_kind,
    input  logic [COORD_BITS-1:0] i_box_left,
    input  logic [COORD_BITS-1:0] i_box_top,
    input  logic [COORD_BITS:0]   i_box_right,
    input  logic [COORD_BITS:0]   i_box_bottom,
    input  logic [9:0]            i_row_pitch,
    input  logic [7:0]            i_glyph_depth,
    input  logic [23:0]           i_ink_color,
    input  logic [7:0]            i_data_byte,
    output logic                  o_push,
    output gbpw_pkg::t_job_hdr    o_hdr,
    output logic [COORD_BITS:0]   o_x,
    output logic [COORD_BITS:0]   o_y
);
    import gbpw_pkg::*;

    localparam int CW = COORD_BITS + 1;

    logic                  r_active, n_active;
    logic                  r_mono, n_mono;
    logic [CW-1:0]         r_x, n_x;
    logic [CW-1:0]         r_y, n_y;
    logic [9:0]            r_rbc, n_rbc;
    logic [COORD_BITS-1:0] r_left, n_left;
    logic [CW-1:0]         r_right, n_right;
    logic [CW-1:0]         r_bottom, n_bottom;
    logic [9:0]            r_pitch, n_pitch;
    logic [23:0]           r_color, n_color;

    logic                  accept;
    logic                  had_pixels;
    logic [CW-1:0]         diff;
    logic [3:0]            bit_cnt;
    logic [CW-1:0]         x_adv;
    logic [9:0]            rbc_adv;
    logic [7:0]            mask;
    logic [CW-1:0]         y_inc;

    assign o_ready = !i_queue_full;
    assign accept  = i_valid && o_ready;
    assign y_inc   = r_y + CW'(1);

    always_comb begin
        had_pixels = r_x < r_right;
        diff       = r_right - r_x;
        bit_cnt    = 4'd0;
        if (had_pixels) begin
            if (diff >= CW'(8)) begin
                bit_cnt = 4'd8;
            end else begin
                bit_cnt = diff[3:0];
            end
        end
        for (int k = 0; k < 8; k++) begin
            mask[k] = (4'(k) < bit_cnt) && i_data_byte[7-k];
        end
        rbc_adv = r_rbc + 10'd1;
    end

    always_comb begin
        n_active = r_active;
        n_mono   = r_mono;
        n_x      = r_x;
        n_y      = r_y;
        n_rbc    = r_rbc;
        n_left   = r_left;
        n_right  = r_right;
        n_bottom = r_bottom;
        n_pitch  = r_pitch;
        n_color  = r_color;
        x_adv    = r_x;
        o_push   = 1'b0;
        o_hdr    = '{st: ST_WRITE, mask: 8'd0, color: r_color};
        o_x      = r_x;
        o_y      = r_y;
        if (i_kind == KIND_START) begin
            n_active = 1'b0;
            if (i_glyph_depth != GLYPH_MONO && i_glyph_depth != GLYPH_GRAY) begin
                o_push = 1'b1;
                o_hdr  = '{st: ST_BAD_GLYPH, mask: 8'd1, color: 24'd0};
            end else begin
                n_mono   = (i_glyph_depth == GLYPH_MONO);
                n_left   = i_box_left;
                n_right  = i_box_right;
                n_bottom = i_box_bottom;
                n_pitch  = i_row_pitch;
                n_color  = i_ink_color;
                n_x      = CW'(i_box_left);
                n_y      = CW'(i_box_top);
                n_rbc    = 10'd0;
                n_active = (i_box_right > CW'(i_box_left)) && (i_box_bottom > CW'(i_box_top));
            end
        end else if (r_active) begin
            if (r_mono) begin
                x_adv  = r_x + CW'(bit_cnt);
                o_push = (mask != 8'd0);
                o_hdr  = '{st: ST_WRITE, mask: mask, color: r_color};
                n_x    = x_adv;
                n_rbc  = rbc_adv;
                if (x_adv >= r_right) begin
                    if (had_pixels && ({1'b0, r_y} + (CW+1)'(1)) >= {1'b0, r_bottom}) begin
                        n_active = 1'b0;
                    end else if (rbc_adv >= r_pitch) begin
                        n_y      = y_inc;
                        n_x      = CW'(r_left);
                        n_rbc    = 10'd0;
                        n_active = !(y_inc >= r_bottom);
                    end
                end
            end else begin
                x_adv  = r_x + CW'(1);
                o_push = (i_data_byte != 8'd0);
                o_hdr  = '{st: ST_WRITE, mask: 8'd1, color: r_color};
                n_x    = x_adv;
                if (x_adv >= r_right) begin
                    n_y      = y_inc;
                    n_x      = CW'(r_left);
                    n_rbc    = 10'd0;
                    n_active = !(y_inc >= r_bottom);
                end
            end
        end
        if (!accept) begin
            o_push = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_mono   <= 1'b0;
            r_x      <= '0;
            r_y      <= '0;
            r_rbc    <= '0;
            r_left   <= '0;
            r_right  <= '0;
            r_bottom <= '0;
            r_pitch  <= '0;
            r_color  <= '0;
        end else if (accept) begin
            r_active <= n_active;
            r_mono   <= n_mono;
            r_x      <= n_x;
            r_y      <= n_y;
            r_rbc    <= n_rbc;
            r_left   <= n_left;
            r_right  <= n_right;
            r_bottom <= n_bottom;
            r_pitch  <= n_pitch;
            r_color  <= n_color;
        end
    end

endmodule

/* hdl/gbpw_queue.sv */
module gbpw_queue #(
    parameter int WIDTH = 60,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [CNTW-1:0]  r_cnt;

    assign o_data  = r_mem[r_rd];
    assign o_full  = (r_cnt == CNTW'(DEPTH));
    assign o_empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CNTW'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CNTW'(1);
            end
        end
    end

endmodule

/* hdl/gbpw_back.sv */
module gbpw_back #(
    parameter int COORD_BITS = 12
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  gbpw_pkg::t_cfg                        i_cfg,
    input  logic                                  i_empty,
    output logic                                  o_pop,
    input  gbpw_pkg::t_job_hdr                    i_hdr,
    input  logic [COORD_BITS:0]                   i_x,
    input  logic [COORD_BITS:0]                   i_y,
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    output logic [gbpw_pkg::OUT_TDATA_BITS-1:0]   o_m_tdata,
    output logic [1:0]                            o_m_tuser,
    output logic                                  o_m_tlast
);
    import gbpw_pkg::*;

    localparam int CW = COORD_BITS + 1;
    localparam int RW = CW + 13;

    logic          r_cv;
    t_job_hdr      r_hdr;
    logic [CW-1:0] r_x;
    logic [RW-1:0] r_row;

    logic          r_ov;
    logic [31:0]   r_addr;
    logic [31:0]   r_data;
    logic [2:0]    r_bytes;
    logic [1:0]    r_st;
    logic          r_last;

    logic          out_free;
    logic          emit;
    logic          done;
    logic [2:0]    k;
    logic [7:0]    rem;
    logic [1:0]    sh;
    logic          fb_ok;
    logic [31:0]   pix;
    logic [CW-1:0] pix_x;
    logic [RW-1:0] row_prod;
    logic [31:0]   n_addr;
    logic [31:0]   n_data;
    logic [2:0]    n_bytes;
    logic [1:0]    n_st;

    assign out_free = !r_ov || i_m_tready;
    assign emit     = r_cv && out_free;
    assign rem      = r_hdr.mask & (r_hdr.mask - 8'd1);
    assign done     = emit && (rem == 8'd0);
    assign o_pop    = !i_empty && (!r_cv || done);
    assign row_prod = RW'(i_y) * RW'(i_cfg.screen_width);
    assign pix_x    = r_x + CW'(k);

    always_comb begin
        k = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (r_hdr.mask[i]) begin
                k = 3'(i);
            end
        end
    end

    always_comb begin
        fb_ok = 1'b1;
        sh    = 2'd0;
        pix   = 32'd0;
        case (i_cfg.frame_depth)
            FB_DEPTH_8: begin
                sh  = 2'd0;
                pix = {24'd0, r_hdr.color[7:0]};
            end
            FB_DEPTH_16: begin
                sh  = 2'd1;
                pix = {16'd0, r_hdr.color[23:19], r_hdr.color[15:10], r_hdr.color[7:3]};
            end
            FB_DEPTH_32: begin
                sh  = 2'd2;
                pix = {8'd0, r_hdr.color};
            end
            default: begin
                fb_ok = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_addr  = 32'd0;
        n_data  = 32'd0;
        n_bytes = 3'd0;
        n_st    = ST_WRITE;
        if (r_hdr.st == ST_BAD_GLYPH) begin
            n_st = ST_BAD_GLYPH;
        end else if (!fb_ok) begin
            n_st = ST_BAD_FRAME;
        end else begin
            n_addr  = i_cfg.frame_base + (32'(r_row) << sh) + (32'(pix_x) << sh);
            n_data  = pix;
            n_bytes = 3'd1 << sh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv <= 1'b0;
        end else if (o_pop) begin
            r_cv <= 1'b1;
        end else if (done) begin
            r_cv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_hdr <= i_hdr;
            r_x   <= i_x;
            r_row <= row_prod;
        end else if (emit) begin
            r_hdr.mask <= rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (emit) begin
            r_ov <= 1'b1;
        end else if (i_m_tready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_addr  <= n_addr;
            r_data  <= n_data;
            r_bytes <= n_bytes;
            r_st    <= n_st;
            r_last  <= (rem == 8'd0);
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {(OUT_TDATA_BITS - 67)'(0), r_bytes, r_data, r_addr};
    assign o_m_tuser  = r_st;
    assign o_m_tlast  = r_last;

endmodule

/* hdl/glyph_bitmap_pixel_writer.sv */
// Glyph bitmap pixel writer.
// Slave stream: tuser = kind (0 glyph start, 1 bitmap byte); tdata carries the box,
// pitch, glyph depth, ink color and data byte. A start item opens a glyph; each data
// byte after it expands to at most eight pixel writes on the master stream.
// Master stream: tdata = address, packed pixel, byte count; tuser = status; tlast
// marks the final result of one input transaction.
// Config channel: index 0 frame base, 1 screen width, 2 frame depth; always ready.
// Write only while the block is idle.
// Throughput: one input transaction per cycle while the 4-entry job queue has room;
// the back end emits one result per cycle while its single output register is free, so
// a byte with several set pixels holds it until all of them (up to 8) are emitted.
// A result passes the job queue, the back-end job register and the output register.
// Reset clears the glyph state, queue and output valid, and restores the config
// defaults (base 0, width 480, depth 16). When the receiver stalls, the output
// register holds its transaction, the back end waits, the queue fills and then
// s_tready drops.
module glyph_bitmap_pixel_writer #(
    parameter int COORD_BITS = 12
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // kind
    input  logic                                  s_tuser,
    // box_left, box_top, box_right, box_bottom, row_pitch, glyph_depth,
    // ink_color, data_byte, zero fill
    input  logic [((4*COORD_BITS+52+7)/8)*8-1:0]  s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // write_address, pixel_data, write_bytes, zero fill
    output logic [gbpw_pkg::OUT_TDATA_BITS-1:0]   m_tdata,
    // status
    output logic [1:0]                            m_tuser,
    // last
    output logic                                  m_tlast,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [1:0]                            i_cfg_index,
    input  logic [31:0]                           i_cfg_data
);
    import gbpw_pkg::*;

    localparam int C   = COORD_BITS;
    localparam int CW  = COORD_BITS + 1;
    localparam int P_L = 0;
    localparam int P_T = P_L + C;
    localparam int P_R = P_T + C;
    localparam int P_B = P_R + CW;
    localparam int P_P = P_B + CW;
    localparam int P_D = P_P + 10;
    localparam int P_I = P_D + 8;
    localparam int P_Y = P_I + 24;
    localparam int HW  = $bits(t_job_hdr);
    localparam int QW  = HW + 2 * CW;

    t_cfg          r_cfg;
    logic          q_full, q_empty, q_push, q_pop;
    t_job_hdr      f_hdr;
    logic [CW-1:0] f_x, f_y;
    logic [QW-1:0] q_head;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{frame_base: 32'd0, screen_width: 13'd480, frame_depth: FB_DEPTH_16};
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_FRAME_BASE:   r_cfg.frame_base   <= i_cfg_data;
                REG_SCREEN_WIDTH: r_cfg.screen_width <= i_cfg_data[12:0];
                REG_FRAME_DEPTH:  r_cfg.frame_depth  <= i_cfg_data[5:0];
                default: begin
                end
            endcase
        end
    end

    gbpw_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_tvalid),
        .o_ready      (s_tready),
        .i_queue_full (q_full),
        .i_kind       (s_tuser),
        .i_box_left   (s_tdata[P_T-1:P_L]),
        .i_box_top    (s_tdata[P_R-1:P_T]),
        .i_box_right  (s_tdata[P_B-1:P_R]),
        .i_box_bottom (s_tdata[P_P-1:P_B]),
        .i_row_pitch  (s_tdata[P_D-1:P_P]),
        .i_glyph_depth(s_tdata[P_I-1:P_D]),
        .i_ink_color  (s_tdata[P_Y-1:P_I]),
        .i_data_byte  (s_tdata[P_Y+7:P_Y]),
        .o_push       (q_push),
        .o_hdr        (f_hdr),
        .o_x          (f_x),
        .o_y          (f_y)
    );

    gbpw_queue #(
        .WIDTH(QW),
        .DEPTH(4)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_data ({f_hdr, f_x, f_y}),
        .i_pop  (q_pop),
        .o_data (q_head),
        .o_full (q_full),
        .o_empty(q_empty)
    );

    gbpw_back #(
        .COORD_BITS(COORD_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_empty   (q_empty),
        .o_pop     (q_pop),
        .i_hdr     (q_head[QW-1:2*CW]),
        .i_x       (q_head[2*CW-1:CW]),
        .i_y       (q_head[CW-1:0]),
        .o_m_tvalid(m_tvalid),
        .i_m_tready(m_tready),
        .o_m_tdata (m_tdata),
        .o_m_tuser (m_tuser),
        .o_m_tlast (m_tlast)
    );

endmodule
